// ===== rtl/core/bounding_volume_overlap_test_core_assert.svh =====
// Assertion macros shared by the overlap test checker.
// Depends on nothing; each user provides clk and rst_n in scope.
`ifndef BOUNDING_VOLUME_OVERLAP_TEST_CORE_ASSERT_SVH
`define BOUNDING_VOLUME_OVERLAP_TEST_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is low
`define BVOT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bvot assertion failed");

// Next-cycle implication, masked while reset is low
`define BVOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bvot assertion failed");

// Next-cycle implication that also runs through reset
`define BVOT_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bvot reset assertion failed");

`endif

// ===== rtl/core/bvot_pkg.sv =====
// Types and constants for the bounding volume overlap test core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package bvot_pkg;

  // Field widths fixed by the transaction format
  localparam int KIND_W  = 2;
  localparam int POS_W   = 48;
  localparam int RAD_W   = 16;
  localparam int REACH_W = 32;
  localparam int WORD_W  = 64;

  // Volume kind codes
  localparam logic [KIND_W-1:0] KIND_SPHERE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELLIPSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX     = 2'd2;

  // Supported {self, other} kind pairs
  localparam logic [2*KIND_W-1:0] PAIR_SPHERE_SPHERE  = {KIND_SPHERE, KIND_SPHERE};
  localparam logic [2*KIND_W-1:0] PAIR_ELLIPSE_SPHERE = {KIND_ELLIPSE, KIND_SPHERE};
  localparam logic [2*KIND_W-1:0] PAIR_ELLIPSE_BOX    = {KIND_ELLIPSE, KIND_BOX};

  typedef struct packed {
    logic [KIND_W-1:0]  self_kind;
    logic [KIND_W-1:0]  other_kind;
    logic [POS_W-1:0]   self_position;
    logic [POS_W-1:0]   other_position;
    logic [RAD_W-1:0]   self_radius;
    logic [RAD_W-1:0]   other_radius;
    logic [REACH_W-1:0] self_reach;
    logic [POS_W-1:0]   box_low_corner;
    logic [POS_W-1:0]   box_high_corner;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic pair_supported;
  } out_item_t;

endpackage

// ===== rtl/core/bvot_prep.sv =====
// Per-lane differences, box clamp and bound selection for one volume pair.
// Depends on bvot_pkg; purely combinational, fed from the input register.
`timescale 1ns / 1ps

module bvot_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  bvot_pkg::in_item_t           item,
  output logic [2:0][COORD_WIDTH:0]    lane_mag,
  output logic [COORD_WIDTH:0]         bound,
  output logic                         pair_supported
);
  import bvot_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [WORD_W-1:0] spos_w, opos_w, low_w, high_w, reach_w, ry_sh, srad_w, orad_w;
  logic [CW-1:0]     rx, ry, srad, orad, rmin;
  logic [2:0][CW:0]  ctr_mag, box_mag;

  // Zero-extend fields to a 64-bit word so lanes past the field read as zero
  assign spos_w  = {{(WORD_W-POS_W){1'b0}}, item.self_position};
  assign opos_w  = {{(WORD_W-POS_W){1'b0}}, item.other_position};
  assign low_w   = {{(WORD_W-POS_W){1'b0}}, item.box_low_corner};
  assign high_w  = {{(WORD_W-POS_W){1'b0}}, item.box_high_corner};
  assign reach_w = {{(WORD_W-REACH_W){1'b0}}, item.self_reach};
  assign srad_w  = {{(WORD_W-RAD_W){1'b0}}, item.self_radius};
  assign orad_w  = {{(WORD_W-RAD_W){1'b0}}, item.other_radius};

  assign ry_sh = reach_w >> CW;
  assign rx    = reach_w[CW-1:0];
  assign ry    = ry_sh[CW-1:0];
  assign srad  = srad_w[CW-1:0];
  assign orad  = orad_w[CW-1:0];
  assign rmin  = (rx < ry) ? rx : ry;

  // One lane per axis: center difference and clamp-to-box difference
  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [WORD_W-1:0]  s_sh, o_sh, l_sh, h_sh;
    logic signed [CW:0] s_c, o_c, lo_b, hi_b, t_c, q_c;
    logic signed [CW+1:0] d_ctr, d_box, a_ctr, a_box;

    assign s_sh = spos_w >> (i * CW);
    assign o_sh = opos_w >> (i * CW);
    assign l_sh = low_w >> (i * CW);
    assign h_sh = high_w >> (i * CW);

    assign s_c  = {s_sh[CW-1], s_sh[CW-1:0]};
    assign o_c  = {o_sh[CW-1], o_sh[CW-1:0]};
    assign lo_b = {l_sh[CW-1], l_sh[CW-1:0]} + o_c;
    assign hi_b = {h_sh[CW-1], h_sh[CW-1:0]} + o_c;

    // Clamp: max(low, min(center, high)); an inverted box yields the low bound
    assign t_c = (s_c < hi_b) ? s_c : hi_b;
    assign q_c = (lo_b > t_c) ? lo_b : t_c;

    assign d_ctr = {s_c[CW], s_c} - {o_c[CW], o_c};
    assign d_box = {q_c[CW], q_c} - {s_c[CW], s_c};
    assign a_ctr = d_ctr[CW+1] ? -d_ctr : d_ctr;
    assign a_box = d_box[CW+1] ? -d_box : d_box;

    assign ctr_mag[i] = a_ctr[CW:0];
    assign box_mag[i] = a_box[CW:0];
  end

  // Pick the operands of the test that this kind pair uses
  always_comb begin
    lane_mag       = '0;
    bound          = '0;
    pair_supported = 1'b0;
    case ({item.self_kind, item.other_kind})
      PAIR_SPHERE_SPHERE: begin
        lane_mag       = ctr_mag;
        bound          = {1'b0, srad} + {1'b0, orad};
        pair_supported = 1'b1;
      end
      PAIR_ELLIPSE_SPHERE: begin
        lane_mag       = ctr_mag;
        bound          = {1'b0, rmin} + {1'b0, orad};
        pair_supported = 1'b1;
      end
      PAIR_ELLIPSE_BOX: begin
        lane_mag       = box_mag;
        bound          = {1'b0, rx};
        pair_supported = 1'b1;
      end
      default: begin
        lane_mag       = '0;
        bound          = '0;
        pair_supported = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/bvot_compare.sv =====
// Sum of squared lane distances against the squared bound.
// Depends on bvot_pkg; combinational, fed from the squares register.
`timescale 1ns / 1ps

module bvot_compare #(
  parameter int COORD_WIDTH = 16
) (
  input  logic [2:0][2*COORD_WIDTH+1:0] lane_sq,
  input  logic [2*COORD_WIDTH+1:0]      bound_sq,
  input  logic                          pair_supported,
  output bvot_pkg::out_item_t           result
);
  import bvot_pkg::*;

  localparam int SQ_W  = 2 * COORD_WIDTH + 2;
  localparam int SUM_W = SQ_W + 2;

  logic [SUM_W-1:0] dist_sq;

  // Full-width sum, nothing wraps
  assign dist_sq = {2'b00, lane_sq[0]} + {2'b00, lane_sq[1]} + {2'b00, lane_sq[2]};

  assign result.pair_supported = pair_supported;
  assign result.hit            = pair_supported && (dist_sq < {2'b00, bound_sq});

endmodule

// ===== rtl/core/bounding_volume_overlap_test_core.sv =====
// Top level of the bounding volume overlap test core.
// Depends on bvot_pkg, bvot_prep and bvot_compare.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one volume pair per
//   transaction (kinds, centers, radii, ellipse reach, box corners, signed
//   fixed-point lanes of COORD_WIDTH bits). The result channel
//   out_valid/out_ready/out_data returns hit and pair_supported for each
//   pair, in order, one result per transaction.
//   The input register loads at the accepting edge; the pair then moves
//   through the lane-difference, square and result registers, and
//   out_valid comes from the result register.
//   Throughput: one pair per cycle while out_ready is high; the four stage
//   registers each hold a transaction and move forward independently.
//   When the receiver holds out_ready low, the result stays on out_data and
//   earlier stages keep filling until every stage holds a transaction; only
//   then does in_ready drop. in_ready depends combinationally on out_ready.
//   Reset (rst_n low, synchronous) empties all stages; no configuration
//   and no state survive between transactions.
//   Unsupported kind pairs return hit 0 and pair_supported 0.
`timescale 1ns / 1ps

module bounding_volume_overlap_test_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvot_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bvot_pkg::out_item_t out_data
);
  import bvot_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int SQ_W = 2 * CW + 2;

  // Stage valids and advance enables
  logic in_v_r, a_v_r, b_v_r, out_v_r;
  logic in_adv, a_adv, b_adv, out_adv;

  // Stage payloads
  in_item_t              in_r;
  logic [2:0][CW:0]      a_mag_r;
  logic [CW:0]           a_bound_r;
  logic                  a_sup_r;
  logic [2:0][SQ_W-1:0]  b_sq_r;
  logic [SQ_W-1:0]       b_bsq_r;
  logic                  b_sup_r;
  out_item_t             out_r;

  // Combinational stage outputs
  logic [2:0][CW:0]      a_mag_nxt;
  logic [CW:0]           a_bound_nxt;
  logic                  a_sup_nxt;
  out_item_t             out_nxt;

  // A stage loads when it is empty or its content moves on
  assign out_adv  = !out_v_r || out_ready;
  assign b_adv    = !b_v_r || out_adv;
  assign a_adv    = !a_v_r || b_adv;
  assign in_adv   = !in_v_r || a_adv;
  assign in_ready = in_adv;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  bvot_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .item           (in_r),
    .lane_mag       (a_mag_nxt),
    .bound          (a_bound_nxt),
    .pair_supported (a_sup_nxt)
  );

  bvot_compare #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_compare (
    .lane_sq        (b_sq_r),
    .bound_sq       (b_bsq_r),
    .pair_supported (b_sup_r),
    .result         (out_nxt)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_adv)  in_v_r  <= in_valid;
      if (a_adv)   a_v_r   <= in_v_r;
      if (b_adv)   b_v_r   <= a_v_r;
      if (out_adv) out_v_r <= b_v_r;
    end
  end

  // Payload registers; one multiplier per lane between a and b
  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_r <= in_data;
    end
    if (a_adv && in_v_r) begin
      a_mag_r   <= a_mag_nxt;
      a_bound_r <= a_bound_nxt;
      a_sup_r   <= a_sup_nxt;
    end
    if (b_adv && a_v_r) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i] <= a_mag_r[i] * a_mag_r[i];
      end
      b_bsq_r <= a_bound_r * a_bound_r;
      b_sup_r <= a_sup_r;
    end
    if (out_adv && b_v_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/core/bvot_checker.sv =====
// Port-level checker for the overlap test core, bound to the top level.
// Depends on bvot_pkg and bounding_volume_overlap_test_core_assert.svh.
`timescale 1ns / 1ps

`include "bounding_volume_overlap_test_core_assert.svh"

module bvot_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bvot_pkg::out_item_t out_data
);
  import bvot_pkg::*;

  // A stalled result holds
  `BVOT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A hit only comes from a supported pair
  `BVOT_ASSERT_NOW(a_hit_supported, out_valid && out_data.hit, out_data.pair_supported)

  // A draining result side never blocks the input side
  `BVOT_ASSERT_NOW(a_ready_flow, out_ready, in_ready)

  // Reset empties the pipeline
  `BVOT_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind bounding_volume_overlap_test_core bvot_checker u_bvot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for bounding_volume_overlap_test_core.
// Depends on bvot_pkg and the core RTL; predicts hit/pair_supported per pair
// and checks every result transaction in order against the prediction.
`timescale 1ns / 1ps

module testbench;
  import bvot_pkg::*;

  localparam int LANE_W       = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE1_START = 360;
  localparam int PHASE2_START = 700;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    bit       drain;
    in_item_t pair;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stim_t     pending_pairs[$];
  out_item_t expected_overlaps[$];
  stim_t     next_pair;
  out_item_t wanted;
  logic      in_taken = 1'b0;
  int        issued = 0;
  int        results_seen = 0;
  int        fail_count = 0;
  int        send_idle;
  int        recv_idle;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  bounding_volume_overlap_test_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Signed lane i of a packed x,y,z word
  function automatic longint lane_at(logic [POS_W-1:0] w, int i);
    logic [LANE_W-1:0] v;
    v = w[i*LANE_W +: LANE_W];
    return longint'($signed(v));
  endfunction

  function automatic longint center_gap_sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    longint acc;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      acc += (lane_at(a, i) - lane_at(b, i)) * (lane_at(a, i) - lane_at(b, i));
    end
    return acc;
  endfunction

  // Overlap decision on exact squared values, full width
  function automatic out_item_t predict_overlap(in_item_t p);
    out_item_t r;
    longint reach_x, reach_y, limit, gap, ctr, lo, hi, q;
    reach_x = longint'(p.self_reach[LANE_W-1:0]);
    reach_y = longint'(p.self_reach[2*LANE_W-1:LANE_W]);
    r = '0;
    case ({p.self_kind, p.other_kind})
      PAIR_SPHERE_SPHERE: begin
        limit = longint'(p.self_radius) + longint'(p.other_radius);
        r.pair_supported = 1'b1;
        r.hit = center_gap_sq(p.self_position, p.other_position) < limit * limit;
      end
      PAIR_ELLIPSE_SPHERE: begin
        limit = ((reach_x < reach_y) ? reach_x : reach_y) + longint'(p.other_radius);
        r.pair_supported = 1'b1;
        r.hit = center_gap_sq(p.self_position, p.other_position) < limit * limit;
      end
      PAIR_ELLIPSE_BOX: begin
        gap = 0;
        for (int i = 0; i < 3; i++) begin
          ctr = lane_at(p.self_position, i);
          lo  = lane_at(p.box_low_corner, i) + lane_at(p.other_position, i);
          hi  = lane_at(p.box_high_corner, i) + lane_at(p.other_position, i);
          // clamp: max(lo, min(ctr, hi)), so an inverted box lands on lo
          q = (ctr < hi) ? ctr : hi;
          if (lo > q) q = lo;
          gap += (q - ctr) * (q - ctr);
        end
        r.pair_supported = 1'b1;
        r.hit = gap < reach_x * reach_x;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pack3(logic [LANE_W-1:0] x, logic [LANE_W-1:0] y,
                                             logic [LANE_W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [POS_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[POS_W-1:0];
  endfunction

  // Random pair: mostly supported kinds with nearby geometry, some pure noise
  function automatic in_item_t random_pair();
    in_item_t p;
    int sel, mag, lo, hi, d;
    logic [LANE_W-1:0] base;
    p.self_position   = rand48();
    p.other_position  = rand48();
    p.self_radius     = RAD_W'($urandom());
    p.other_radius    = RAD_W'($urandom());
    p.self_reach      = $urandom();
    p.box_low_corner  = rand48();
    p.box_high_corner = rand48();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      p.self_kind  = KIND_SPHERE;
      p.other_kind = KIND_SPHERE;
    end else if (sel < 60) begin
      p.self_kind  = KIND_ELLIPSE;
      p.other_kind = KIND_SPHERE;
    end else if (sel < 90) begin
      p.self_kind  = KIND_ELLIPSE;
      p.other_kind = KIND_BOX;
    end else begin
      p.self_kind  = KIND_W'($urandom_range(0, 3));
      p.other_kind = KIND_W'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 3) != 0) begin
      mag = 1 << $urandom_range(2, 14);
      p.self_radius  = RAD_W'($urandom_range(0, mag));
      p.other_radius = RAD_W'($urandom_range(0, mag));
      p.self_reach   = {LANE_W'($urandom_range(0, mag)), LANE_W'($urandom_range(0, mag))};
      for (int i = 0; i < 3; i++) begin
        base = p.self_position[i*LANE_W +: LANE_W];
        d = int'($urandom_range(0, 2 * mag)) - mag;
        p.other_position[i*LANE_W +: LANE_W] = base + LANE_W'(d);
        lo = $urandom_range(0, mag);
        hi = $urandom_range(0, mag);
        if ($urandom_range(0, 9) == 0) begin
          // inverted box on this axis
          p.box_low_corner[i*LANE_W +: LANE_W]  = LANE_W'(lo);
          p.box_high_corner[i*LANE_W +: LANE_W] = LANE_W'(-hi);
        end else begin
          p.box_low_corner[i*LANE_W +: LANE_W]  = LANE_W'(-lo);
          p.box_high_corner[i*LANE_W +: LANE_W] = LANE_W'(hi);
        end
      end
    end
    return p;
  endfunction

  task automatic add_pair(logic [KIND_W-1:0] sk, logic [KIND_W-1:0] ok,
                          logic [POS_W-1:0] sp, logic [POS_W-1:0] op,
                          logic [RAD_W-1:0] sr, logic [RAD_W-1:0] orr,
                          logic [REACH_W-1:0] rch,
                          logic [POS_W-1:0] lc, logic [POS_W-1:0] hc);
    stim_t s;
    s.drain = 1'b0;
    s.pair  = '{sk, ok, sp, op, sr, orr, rch, lc, hc};
    pending_pairs.push_back(s);
  endtask

  task automatic note_failure(string what, out_item_t want, out_item_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s at result %0d: expected hit=%0b supported=%0b, got hit=%0b supported=%0b",
               what, results_seen, want.hit, want.pair_supported, got.hit, got.pair_supported);
    end
  endtask

  // Driver: offers the next pending pair at the falling edge
  always @(negedge clk) begin
    send_idle = (issued < PHASE1_START) ? 14 : (issued < PHASE2_START) ? 58 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_pairs.size() != 0 &&
          !(pending_pairs[0].drain && expected_overlaps.size() != 0) &&
          $urandom_range(0, 99) >= send_idle) begin
        next_pair = pending_pairs.pop_front();
        in_data  <= next_pair.pair;
        in_valid <= 1'b1;
        issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    recv_idle = (issued < PHASE1_START) ? 58 : (issued < PHASE2_START) ? 14 : 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: check results first, then record the accepted input transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_overlaps.size() == 0) begin
          note_failure("unexpected result", '0, out_data);
        end else begin
          wanted = expected_overlaps.pop_front();
          if (out_data.hit !== wanted.hit ||
              out_data.pair_supported !== wanted.pair_supported) begin
            note_failure("mismatch", wanted, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_overlaps.push_back(predict_overlap(in_data));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    stim_t s;
    int sk, ok;

    // every kind pair, with geometry that overlaps wherever a test exists
    for (sk = 0; sk < 4; sk++) begin
      for (ok = 0; ok < 4; ok++) begin
        add_pair(KIND_W'(sk), KIND_W'(ok), pack3(16'h0100, 16'hFF00, 16'h0000),
                 pack3(16'h0180, 16'hFF00, 16'h0000), 16'h0100, 16'h0100, 32'h0200_0200,
                 pack3(16'hFF00, 16'hFF00, 16'hFF00), pack3(16'h0100, 16'h0100, 16'h0100));
      end
    end
    // spheres exactly touching, then one LSB closer
    add_pair(KIND_SPHERE, KIND_SPHERE, '0, pack3(16'h0200, 16'h0000, 16'h0000), 16'h0100,
             16'h0100, '0, '0, '0);
    add_pair(KIND_SPHERE, KIND_SPHERE, '0, pack3(16'h01FF, 16'h0000, 16'h0000), 16'h0100,
             16'h0100, '0, '0, '0);
    // opposite extreme centers, largest radii
    add_pair(KIND_SPHERE, KIND_SPHERE, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
             pack3(16'h8000, 16'h8000, 16'h8000), 16'hFFFF, 16'hFFFF, '0, '0, '0);
    // ellipse reach: smaller lane is y, then x
    add_pair(KIND_ELLIPSE, KIND_SPHERE, '0, pack3(16'h0200, 16'h0000, 16'h0000), 16'h0000,
             16'h0100, 32'h0100_0400, '0, '0);
    add_pair(KIND_ELLIPSE, KIND_SPHERE, '0, pack3(16'h01FF, 16'h0000, 16'h0000), 16'h0000,
             16'h0100, 32'h0400_0100, '0, '0);
    // ellipse outside a box: touching, then just reaching
    add_pair(KIND_ELLIPSE, KIND_BOX, pack3(16'h0300, 16'h0000, 16'h0000), '0, '0, '0,
             32'h0000_0200,
             pack3(16'hFF00, 16'hFF00, 16'hFF00), pack3(16'h0100, 16'h0100, 16'h0100));
    add_pair(KIND_ELLIPSE, KIND_BOX, pack3(16'h0300, 16'h0000, 16'h0000), '0, '0, '0,
             32'h0000_0201,
             pack3(16'hFF00, 16'hFF00, 16'hFF00), pack3(16'h0100, 16'h0100, 16'h0100));
    // inverted box clamps to the low corner on every axis
    add_pair(KIND_ELLIPSE, KIND_BOX, '0, '0, '0, '0, 32'h0000_01BC,
             pack3(16'h0100, 16'h0100, 16'h0100), pack3(16'hFF00, 16'hFF00, 16'hFF00));
    add_pair(KIND_ELLIPSE, KIND_BOX, '0, '0, '0, '0, 32'h0000_01BB,
             pack3(16'h0100, 16'h0100, 16'h0100), pack3(16'hFF00, 16'hFF00, 16'hFF00));
    // box bounds beyond the lane range must not wrap
    add_pair(KIND_ELLIPSE, KIND_BOX, pack3(16'h8000, 16'h8000, 16'h8000),
             pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), '0, '0, 32'hFFFF_FFFF,
             pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h7FFF, 16'h7FFF, 16'h7FFF));

    // random part; the sender drains the block at a few points
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      s.drain = (n == 0) || (n == 500) || (n == 800);
      s.pair  = random_pair();
      pending_pairs.push_back(s);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_pairs.size() != 0 || in_valid || expected_overlaps.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_overlaps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== bounding_volume_overlap_test_core.f =====
+incdir+rtl/core
rtl/core/bvot_pkg.sv
rtl/core/bvot_prep.sv
rtl/core/bvot_compare.sv
rtl/core/bounding_volume_overlap_test_core.sv
rtl/core/bvot_checker.sv
tb/testbench.sv
